@@ src/cbtb_pkg.sv @@
// ----------------------------------------------------------------------------
// cbtb_pkg
// Shared types and constants of the clipped 2bpp blitter: register map,
// configuration bundle, pixel work item and result item.
// ----------------------------------------------------------------------------
package cbtb_pkg;

   typedef enum logic [2:0] {
      REG_DEST_X     = 3'd0,
      REG_DEST_Y     = 3'd1,
      REG_SRC_WIDTH  = 3'd2,
      REG_SRC_HEIGHT = 3'd3,
      REG_MODE       = 3'd4,
      REG_PALETTE    = 3'd5
   } reg_index_type;

   // mode register bits
   localparam int MODE_SWAP  = 0;
   localparam int MODE_REV_X = 1;
   localparam int MODE_REV_Y = 2;
   localparam int MODE_TRANS = 3;

   localparam logic [1:0] LAST_SLOT = 2'd3;   // fourth index of a byte

   typedef struct packed {
      logic signed [11:0] dest_x;
      logic signed [11:0] dest_y;
      logic [7:0]         src_width;
      logic [7:0]         src_height;
      logic [3:0]         mode;
      logic [31:0]        palette;
   } cfg_type;

   // one source pixel, classified by the front end
   typedef struct packed {
      logic [1:0] ix;
      logic [7:0] sx;
      logic [7:0] sy;
      logic       last;
      logic       done;
   } pix_type;

   typedef struct packed {
      logic [12:0] write_address;
      logic [7:0]  pixel_value;
      logic        write_enable;
      logic        last_of_byte;
      logic        blit_done;
   } rsp_type;

endpackage

@@ src/cbtb_fifo.sv @@
// ----------------------------------------------------------------------------
// cbtb_fifo
// Small register queue with push/full and pop/empty; head shown while not
// empty.
// ----------------------------------------------------------------------------
module cbtb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/cbtb_front.sv @@
// ----------------------------------------------------------------------------
// cbtb_front
// Takes source bytes, walks their four indices against the source column and
// row counters and emits one pixel work item per cycle while q_full is low.
// ----------------------------------------------------------------------------
module cbtb_front (
   input  logic              clock,
   input  logic              reset,
   input  cbtb_pkg::cfg_type cfg,
   input  logic              push,
   input  logic [7:0]        src_byte,
   output logic              full,
   input  logic              q_full,
   output logic              q_push,
   output cbtb_pkg::pix_type q_item
);

   logic       busy_ff, busy_in;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] slot_ff, slot_in;
   logic [7:0] column_ff, column_in;
   logic [7:0] row_ff, row_in;

   logic       emit, row_end, blit_end, last, free, accept;
   logic [7:0] col_inc, column_nx, row_nx, shifted;
   logic [8:0] row_inc;

   always_comb begin
      emit     = busy_ff && !q_full;
      shifted  = byte_ff << {slot_ff, 1'b0};
      col_inc  = column_ff + 8'd1;
      row_end  = (col_inc >= cfg.src_width);
      row_inc  = {1'b0, row_ff} + 9'd1;
      blit_end = (row_inc >= {1'b0, cfg.src_height});
      last     = row_end || (slot_ff == cbtb_pkg::LAST_SLOT);

      column_nx = column_ff;
      row_nx    = row_ff;
      if (emit) begin
         column_nx = row_end ? 8'd0 : col_inc;
         if (row_end) begin
            row_nx = blit_end ? 8'd0 : row_inc[7:0];
         end
      end

      free   = !busy_ff || (emit && last);
      full   = !free;
      accept = push && free;

      busy_in   = busy_ff;
      byte_in   = byte_ff;
      slot_in   = slot_ff;
      column_in = column_nx;
      row_in    = row_nx;
      if (accept) begin
         byte_in = src_byte;
         slot_in = 2'd0;
         // a column left beyond a shrunken width restarts the row
         column_in = (column_nx >= cfg.src_width) ? 8'd0 : column_nx;
         busy_in   = (cfg.src_width != 8'd0);
      end else if (emit) begin
         slot_in = slot_ff + 2'd1;
         busy_in = !last;
      end

      q_push      = emit;
      q_item.ix   = shifted[7:6];
      q_item.sx   = column_ff;
      q_item.sy   = row_ff;
      q_item.last = last;
      q_item.done = row_end && blit_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         busy_ff   <= busy_in;
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      slot_ff <= slot_in;
   end

endmodule

@@ src/cbtb_back.sv @@
// ----------------------------------------------------------------------------
// cbtb_back
// Two-stage pixel pipe: transform and offset, then clip, address and palette
// lookup. Stalls when the result queue is full while stage 1 holds a pixel.
// ----------------------------------------------------------------------------
module cbtb_back #(
   parameter int FB_WIDTH  = 128,
   parameter int FB_HEIGHT = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  cbtb_pkg::cfg_type cfg,
   input  cbtb_pkg::pix_type q_item,
   input  logic              q_empty,
   output logic              q_pop,
   input  logic              out_full,
   output logic              out_push,
   output cbtb_pkg::rsp_type out_item
);

   localparam logic signed [12:0] FB_W_S     = 13'(FB_WIDTH);
   localparam logic signed [12:0] FB_H_S     = 13'(FB_HEIGHT);
   localparam logic [12:0]        FB_WIDTH_LO = 13'(FB_WIDTH);

   logic               s1_valid_ff, s1_valid_in;
   logic signed [12:0] s1_col_ff, s1_col_in;
   logic signed [12:0] s1_row_ff, s1_row_in;
   logic [1:0]         s1_ix_ff, s1_ix_in;
   logic               s1_last_ff, s1_last_in;
   logic               s1_done_ff, s1_done_in;

   logic               advance, in_fb;
   logic [7:0]         sx_t, sy_t, c_src, r_src;
   logic signed [12:0] c_ext, r_ext, dx_ext, dy_ext;
   logic [12:0]        row_u, col_u;
   logic [31:0]        pal_shift;

   // stage 1: reverse, swap, add destination corner
   always_comb begin
      advance = !s1_valid_ff || !out_full;
      q_pop   = advance && !q_empty;

      sx_t = cfg.mode[cbtb_pkg::MODE_REV_X] ? (cfg.src_width - 8'd1 - q_item.sx) : q_item.sx;
      sy_t = cfg.mode[cbtb_pkg::MODE_REV_Y] ? (cfg.src_height - 8'd1 - q_item.sy) : q_item.sy;
      if (cfg.mode[cbtb_pkg::MODE_SWAP]) begin
         c_src = sy_t;
         r_src = sx_t;
      end else begin
         c_src = sx_t;
         r_src = sy_t;
      end
      c_ext  = {5'd0, c_src};
      r_ext  = {5'd0, r_src};
      dx_ext = {cfg.dest_x[11], cfg.dest_x};
      dy_ext = {cfg.dest_y[11], cfg.dest_y};

      s1_valid_in = s1_valid_ff;
      s1_col_in   = s1_col_ff;
      s1_row_in   = s1_row_ff;
      s1_ix_in    = s1_ix_ff;
      s1_last_in  = s1_last_ff;
      s1_done_in  = s1_done_ff;
      if (advance) begin
         s1_valid_in = !q_empty;
         s1_col_in   = c_ext + dx_ext;
         s1_row_in   = r_ext + dy_ext;
         s1_ix_in    = q_item.ix;
         s1_last_in  = q_item.last;
         s1_done_in  = q_item.done;
      end
   end

   // stage 2: clip, address, colour
   always_comb begin
      in_fb = !s1_col_ff[12] && (s1_col_ff < FB_W_S) &&
              !s1_row_ff[12] && (s1_row_ff < FB_H_S);
      row_u     = s1_row_ff;
      col_u     = s1_col_ff;
      pal_shift = cfg.palette >> {s1_ix_ff, 3'b000};

      out_push               = s1_valid_ff && !out_full;
      out_item.write_address = in_fb ? (row_u * FB_WIDTH_LO + col_u) : 13'd0;
      out_item.pixel_value   = pal_shift[7:0];
      out_item.write_enable  = in_fb &&
                               !(cfg.mode[cbtb_pkg::MODE_TRANS] && (s1_ix_ff == 2'd0));
      out_item.last_of_byte  = s1_last_ff;
      out_item.blit_done     = s1_done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_col_ff  <= s1_col_in;
      s1_row_ff  <= s1_row_in;
      s1_ix_ff   <= s1_ix_in;
      s1_last_ff <= s1_last_in;
      s1_done_ff <= s1_done_in;
   end

endmodule

@@ src/clipped_transformed_2bpp_blitter.sv @@
// ----------------------------------------------------------------------------
// clipped_transformed_2bpp_blitter
// Sprite blitter for 2bpp textures with flip/rotate and framebuffer clipping.
// ----------------------------------------------------------------------------
// Usage:
//   req_ side is a queue input: drive req_src_byte and raise req_push; a beat
//   is taken at a clock edge where req_full is low. Bytes come in row order,
//   four 2-bit indices each, leftmost in bits 7:6; a row starts a new byte.
//   rsp_ side is a queue output: while rsp_empty is low the oldest pixel
//   write sits on the rsp_ ports; rsp_pop takes it. Each byte gives one to
//   four pixel beats (fewer when a row ends inside the byte, none when
//   src_width is zero); last_of_byte marks the final one, blit_done the
//   last pixel of the texture.
//   csr_ port writes dest_x, dest_y, src_width, src_height, mode, palette by
//   index; write only while the block is idle.
// Timing: the front end issues one pixel per cycle while the work queue has
//   room, and takes the next byte as the last pixel of a byte is issued. A byte
//   passes the byte register, work queue, stage 1 and result queue to rsp_.
// Reset: synchronous; queues empty, counters at zero, registers at defaults.
// Stalls: rsp_pop held low backs up the result queue, the pixel pipe and the
//   work queue in turn, then raises req_full; nothing is dropped.
// ----------------------------------------------------------------------------
module clipped_transformed_2bpp_blitter #(
   parameter int FB_WIDTH  = 128,
   parameter int FB_HEIGHT = 64
) (
   input  logic        clock,
   input  logic        reset,
   // source byte queue
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_src_byte,
   // pixel write queue
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [12:0] rsp_write_address,
   output logic [7:0]  rsp_pixel_value,
   output logic        rsp_write_enable,
   output logic        rsp_last_of_byte,
   output logic        rsp_blit_done,
   // register writes
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cbtb_pkg::cfg_type cfg_ff, cfg_in;
   cbtb_pkg::pix_type front_item, mid_item;
   cbtb_pkg::rsp_type back_item, rsp_item;

   logic front_push, mid_full, mid_pop, mid_empty, out_push, out_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (cbtb_pkg::reg_index_type'(csr_index))
            cbtb_pkg::REG_DEST_X:     cfg_in.dest_x     = csr_wdata[11:0];
            cbtb_pkg::REG_DEST_Y:     cfg_in.dest_y     = csr_wdata[11:0];
            cbtb_pkg::REG_SRC_WIDTH:  cfg_in.src_width  = csr_wdata[7:0];
            cbtb_pkg::REG_SRC_HEIGHT: cfg_in.src_height = csr_wdata[7:0];
            cbtb_pkg::REG_MODE:       cfg_in.mode       = csr_wdata[3:0];
            cbtb_pkg::REG_PALETTE:    cfg_in.palette    = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dest_x     <= '0;
         cfg_ff.dest_y     <= '0;
         cfg_ff.src_width  <= 8'd8;
         cfg_ff.src_height <= 8'd8;
         cfg_ff.mode       <= '0;
         cfg_ff.palette    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cbtb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (req_push),
      .src_byte (req_src_byte),
      .full     (req_full),
      .q_full   (mid_full),
      .q_push   (front_push),
      .q_item   (front_item)
   );

   cbtb_fifo #(
      .WIDTH ($bits(cbtb_pkg::pix_type)),
      .DEPTH (2)
   ) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_item),
      .empty     (mid_empty)
   );

   cbtb_back #(
      .FB_WIDTH  (FB_WIDTH),
      .FB_HEIGHT (FB_HEIGHT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_item   (mid_item),
      .q_empty  (mid_empty),
      .q_pop    (mid_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_item (back_item)
   );

   cbtb_fifo #(
      .WIDTH ($bits(cbtb_pkg::rsp_type)),
      .DEPTH (2)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_item),
      .empty     (rsp_empty)
   );

   assign rsp_write_address = rsp_item.write_address;
   assign rsp_pixel_value   = rsp_item.pixel_value;
   assign rsp_write_enable  = rsp_item.write_enable;
   assign rsp_last_of_byte  = rsp_item.last_of_byte;
   assign rsp_blit_done     = rsp_item.blit_done;

endmodule

@@ tb/sv/tb_clipped_transformed_2bpp_blitter.sv @@
// ----------------------------------------------------------------------------
// tb_clipped_transformed_2bpp_blitter
// Self-checking bench for the 2bpp blitter. Source bytes go in through the
// req_ queue, and pixel writes come back through the rsp_ queue. A local
// blitter model tracks the source column and row and the register values.
// It predicts every pixel beat, and each popped beat is checked against the
// oldest prediction. Directed tests cover reset defaults, each transform
// bit, clipping at the extremes, rows that end inside a byte, shrinking the
// texture during a blit, and zero and maximum sizes. After that, random
// blits with random placement, mode and palette are run under random gaps
// on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_clipped_transformed_2bpp_blitter;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB_W = 128;
   localparam int FB_H = 64;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_BYTES = 75;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_src_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [12:0] rsp_write_address;
   logic [7:0]  rsp_pixel_value;
   logic        rsp_write_enable;
   logic        rsp_last_of_byte;
   logic        rsp_blit_done;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   // blitter model: register copy, source counters, pending pixel writes
   cbtb_pkg::cfg_type blit_cfg;
   logic [7:0]        src_col;
   logic [7:0]        src_row;
   cbtb_pkg::rsp_type pixel_writes_due[$];

   int  fail_count;
   bit  feed_gaps;
   bit  pop_stalls;
   int  stall_left;

   clipped_transformed_2bpp_blitter #(
      .FB_WIDTH  (FB_W),
      .FB_HEIGHT (FB_H)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_src_byte      (req_src_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_write_address (rsp_write_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_last_of_byte  (rsp_last_of_byte),
      .rsp_blit_done     (rsp_blit_done),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // mostly short, now and then long
   function automatic int burst_len();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // pixel beats caused by one source byte, in order
   function automatic void predict_pixel_writes(input logic [7:0] src_byte);
      int                p;
      int                col;
      int                row;
      bit                stop;
      bit                in_fb;
      bit                row_end;
      logic [1:0]        ix;
      logic [7:0]        sx;
      logic [7:0]        sy;
      cbtb_pkg::rsp_type px;
      stop = 1'b0;
      if (src_col >= blit_cfg.src_width)
         src_col = 8'd0;
      for (p = 0; p < 4 && !stop && src_col < blit_cfg.src_width; p++) begin
         ix = src_byte[6 - 2 * p +: 2];
         sx = src_col;
         sy = src_row;
         if (blit_cfg.mode[cbtb_pkg::MODE_REV_X])
            sx = blit_cfg.src_width - 8'd1 - sx;
         if (blit_cfg.mode[cbtb_pkg::MODE_REV_Y])
            sy = blit_cfg.src_height - 8'd1 - sy;
         if (blit_cfg.mode[cbtb_pkg::MODE_SWAP]) begin
            col = int'(sy);
            row = int'(sx);
         end else begin
            col = int'(sx);
            row = int'(sy);
         end
         col = col + int'($signed(blit_cfg.dest_x));
         row = row + int'($signed(blit_cfg.dest_y));
         in_fb = col >= 0 && col < FB_W && row >= 0 && row < FB_H;

         px.write_address = in_fb ? 13'(row * FB_W + col) : 13'd0;
         px.pixel_value   = blit_cfg.palette[8 * ix +: 8];
         px.write_enable  = in_fb && !(blit_cfg.mode[cbtb_pkg::MODE_TRANS] && ix == 2'd0);
         px.blit_done     = 1'b0;

         src_col = src_col + 8'd1;
         row_end = src_col >= blit_cfg.src_width;
         if (row_end) begin
            src_col = 8'd0;
            if ({1'b0, src_row} + 9'd1 >= {1'b0, blit_cfg.src_height}) begin
               px.blit_done = 1'b1;
               src_row = 8'd0;
            end else begin
               src_row = src_row + 8'd1;
            end
            stop = 1'b1;
         end
         // the loop only ends on a row end or on the fourth index
         px.last_of_byte = row_end || p == 3;
         pixel_writes_due.push_back(px);
      end
   endfunction

   // req_full only moves at rising edges, so the falling edge shows what the
   // next rising edge will see
   task automatic send_byte(input logic [7:0] src_byte);
      int gap;
      req_push     <= 1'b1;
      req_src_byte <= src_byte;
      @(negedge clock);
      while (req_full)
         @(negedge clock);
      @(posedge clock);
      predict_pixel_writes(src_byte);
      gap = (feed_gaps && $urandom_range(0, 3) == 0) ? burst_len() : 0;
      if (gap > 0) begin
         req_push     <= 1'b0;
         req_src_byte <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for every predicted beat, then let a byte with no beats finish
   task automatic settle();
      req_push <= 1'b0;
      while (pixel_writes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // writes all six registers; unused upper data bits carry noise
   task automatic load_settings(input cbtb_pkg::cfg_type c);
      cbtb_pkg::reg_index_type idx;
      logic [31:0]             word;
      settle();
      idx = idx.first();
      for (int k = 0; k < idx.num(); k++) begin
         word = $urandom;
         case (idx)
            cbtb_pkg::REG_DEST_X:     word[11:0] = c.dest_x;
            cbtb_pkg::REG_DEST_Y:     word[11:0] = c.dest_y;
            cbtb_pkg::REG_SRC_WIDTH:  word[7:0]  = c.src_width;
            cbtb_pkg::REG_SRC_HEIGHT: word[7:0]  = c.src_height;
            cbtb_pkg::REG_MODE:       word[3:0]  = c.mode;
            cbtb_pkg::REG_PALETTE:    word       = c.palette;
            default:                  word       = word;
         endcase
         csr_write <= 1'b1;
         csr_index <= idx;
         csr_wdata <= word;
         @(posedge clock);
         idx = idx.next();
      end
      csr_write <= 1'b0;
      blit_cfg = c;
   endtask

   function automatic cbtb_pkg::cfg_type make_cfg(input int x, input int y, input int w,
                                                  input int h, input logic [3:0] mode,
                                                  input logic [31:0] pal);
      cbtb_pkg::cfg_type c;
      c.dest_x     = 12'(x);
      c.dest_y     = 12'(y);
      c.src_width  = 8'(w);
      c.src_height = 8'(h);
      c.mode       = mode;
      c.palette    = pal;
      return c;
   endfunction

   function automatic int pick_offset(input int span);
      case ($urandom_range(0, 7))
         0:       return -2048;
         1:       return 2047;
         2:       return int'($signed(12'($urandom)));
         default: return int'($urandom_range(0, span + 40)) - 20;
      endcase
   endfunction

   // result side: check the beat that the coming rising edge takes
   always @(negedge clock) begin
      cbtb_pkg::rsp_type got;
      cbtb_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = '{rsp_write_address, rsp_pixel_value, rsp_write_enable,
                 rsp_last_of_byte, rsp_blit_done};
         if (pixel_writes_due.size() == 0) begin
            $display("%0t: unexpected beat addr=%0d val=%02h we=%0b last=%0b done=%0b",
                     $realtime, got.write_address, got.pixel_value, got.write_enable,
                     got.last_of_byte, got.blit_done);
            fail_count++;
         end else begin
            want = pixel_writes_due.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected addr=%0d val=%02h we=%0b last=%0b done=%0b",
                        $realtime, want.write_address, want.pixel_value,
                        want.write_enable, want.last_of_byte, want.blit_done);
               $display("%0t:          actual   addr=%0d val=%02h we=%0b last=%0b done=%0b",
                        $realtime, got.write_address, got.pixel_value,
                        got.write_enable, got.last_of_byte, got.blit_done);
               fail_count++;
            end
         end
      end
   end

   // decide pop for the next cycle
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_pop <= 1'b0;
         stall_left--;
      end else begin
         rsp_pop <= 1'b1;
         if (pop_stalls && $urandom_range(0, 5) == 0)
            stall_left = burst_len();
      end
   end

   task automatic test_reset_defaults();
      // 8x8 texture at the origin, palette all zero
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   task automatic test_transform_modes();
      logic [3:0] modes[6];
      modes = '{4'd0, 4'(1 << cbtb_pkg::MODE_SWAP), 4'(1 << cbtb_pkg::MODE_REV_X),
                4'(1 << cbtb_pkg::MODE_REV_Y), 4'(1 << cbtb_pkg::MODE_TRANS), 4'hF};
      foreach (modes[m]) begin
         load_settings(make_cfg(4, 2, 2, 2, modes[m], 32'hC3_82_41_00));
         send_byte(8'hE4);
         send_byte(8'h1B);
      end
   endtask

   task automatic test_clipping();
      load_settings(make_cfg(-2048, 2047, 4, 1, 4'd0, 32'hFFFF_FFFF));
      send_byte(8'hE4);
      load_settings(make_cfg(126, 63, 4, 1, 4'(1 << cbtb_pkg::MODE_TRANS), 32'hA5_5A_F0_0F));
      send_byte(8'h39);
      load_settings(make_cfg(-1, -1, 4, 1, 4'(1 << cbtb_pkg::MODE_SWAP), 32'h0102_0304));
      send_byte(8'hE4);
   endtask

   task automatic test_row_end_in_byte();
      // width 5: the second byte carries one pixel and three padding indices
      load_settings(make_cfg(10, 10, 5, 1, 4'd0, 32'h7766_5544));
      send_byte(8'hAA);
      send_byte(8'h55);
   endtask

   task automatic test_shrink_mid_blit();
      load_settings(make_cfg(0, 0, 8, 4, 4'd0, 32'h1234_5678));
      send_byte(8'h1E);
      send_byte(8'hD2);
      send_byte(8'h4B);
      // column and row now lie beyond the new size
      load_settings(make_cfg(3, 5, 2, 1, 4'(1 << cbtb_pkg::MODE_REV_Y), 32'h8765_4321));
      send_byte(8'hC6);
   endtask

   task automatic test_size_extremes();
      load_settings(make_cfg(0, 0, 0, 4, 4'd0, 32'h1111_1111));
      send_byte(8'hFF);
      load_settings(make_cfg(0, 0, 4, 0, 4'(1 << cbtb_pkg::MODE_REV_Y), 32'h2222_2222));
      send_byte(8'h6C);
      load_settings(make_cfg(0, 0, 255, 255, 4'h6, 32'h0F1E_2D3C));
      send_byte(8'h93);
   endtask

   task automatic test_random_blits();
      int                sent;
      int                w;
      int                h;
      int                n_bytes;
      cbtb_pkg::cfg_type c;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 9) == 0) begin
            w = 255;
            h = 1;
         end else begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 5);
         end
         c = make_cfg(pick_offset(FB_W), pick_offset(FB_H), w, h,
                      4'($urandom), $urandom);
         load_settings(c);
         feed_gaps  = $urandom_range(0, 3) != 0;
         pop_stalls = $urandom_range(0, 3) != 0;
         n_bytes = ((w + 3) / 4) * h;
         // now and then stop short, leaving the counters mid texture
         if ($urandom_range(0, 5) == 0)
            n_bytes = $urandom_range(1, n_bytes);
         if (n_bytes > RANDOM_BYTES - sent)
            n_bytes = RANDOM_BYTES - sent;
         repeat (n_bytes) begin
            send_byte(8'($urandom_range(0, 255)));
            sent++;
         end
      end
   endtask

   initial begin
      reset        <= 1'b1;
      req_push     <= 1'b0;
      req_src_byte <= 8'd0;
      rsp_pop      <= 1'b0;
      csr_write    <= 1'b0;
      csr_index    <= cbtb_pkg::REG_DEST_X;
      csr_wdata    <= 32'd0;
      fail_count   = 0;
      stall_left   = 0;
      feed_gaps    = 1'b1;
      pop_stalls   = 1'b1;
      blit_cfg     = make_cfg(0, 0, 8, 8, 4'd0, 32'd0);
      src_col      = 8'd0;
      src_row      = 8'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_transform_modes();
      test_clipping();
      test_row_end_in_byte();
      test_shrink_mid_blit();
      test_size_extremes();
      test_random_blits();
      settle();

      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d pixel beats outstanding", pixel_writes_due.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
